@@ rtl/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the two-key record sorter
// Record layouts, queue entry, result bundle and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

  localparam int ID_W   = 16;
  localparam int NAME_W = 64;
  localparam int AGE_W  = 8;

  localparam int DEF_MAX_RECORDS = 64;
  localparam int DEF_NAME_BYTES  = 8;

  // depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NAME_W-1:0] name;
    logic [AGE_W-1:0]  age;
  } rec_t;

  // record as held for ranking: payload plus left-aligned name key
  typedef struct packed {
    rec_t              rec;
    logic [NAME_W-1:0] key;
  } keyed_t;

  typedef struct packed {
    rec_t              rec;
    logic [NAME_W-1:0] key;
    logic              last;
    logic              mode;
  } entry_t;

  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/two_key_record_sorter.sv @@
// ----------------------------------------------------------------------------
// two_key_record_sorter: stable record sorter by name or by age then name
// Collects a set of records and emits them in ascending order once the
// record marked last has arrived.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  input    | in        | push / full          | record_id name_chars age_value
//           |           |                      | last_record
//  result   | out       | empty / pop          | out_id out_name out_age
//           |           |                      | out_last overflow_flag
//  config   | in        | cfg_valid / cfg_ready| cfg_data (sort_mode)
//
//  Records enter the front queue at one per cycle while it has room.
//  Ranking fetches each record of a set and compares it against the whole
//  set through the store's single read port. Each result passes through a
//  sorted RAM read, then the output slot; a read waits for the one before.
//  full rises when the four-entry queue fills while the back is busy.
//  Reset clears control state only; the record memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module two_key_record_sorter #(
  parameter int MAX_RECORDS = tks_pkg::DEF_MAX_RECORDS,
  parameter int NAME_BYTES  = tks_pkg::DEF_NAME_BYTES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output      logic                      full,
  input  wire logic [tks_pkg::ID_W-1:0]   record_id,
  input  wire logic [tks_pkg::NAME_W-1:0] name_chars,
  input  wire logic [tks_pkg::AGE_W-1:0]  age_value,
  input  wire logic                      last_record,
  output      logic                      empty,
  input  wire logic                      pop,
  output      logic [tks_pkg::ID_W-1:0]   out_id,
  output      logic [tks_pkg::NAME_W-1:0] out_name,
  output      logic [tks_pkg::AGE_W-1:0]  out_age,
  output      logic                      out_last,
  output      logic                      overflow_flag,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic                      cfg_data
);
  import tks_pkg::*;

  logic   q_push;
  logic   q_full;
  entry_t q_in;
  logic   q_pop;
  logic   q_valid;
  entry_t q_out;
  logic   out_valid;
  res_t   res;

  tks_front #(
    .NAME_BYTES (NAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .record_id   (record_id),
    .name_chars  (name_chars),
    .age_value   (age_value),
    .last_record (last_record),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  tks_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_out)
  );

  tks_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res)
  );

  assign full          = q_full;
  assign empty         = !out_valid;
  assign out_id        = res.rec.id;
  assign out_name      = res.rec.name;
  assign out_age       = res.rec.age;
  assign out_last      = res.last;
  assign overflow_flag = res.ovf;

endmodule

`default_nettype wire

@@ rtl/tks_ram.sv @@
// ----------------------------------------------------------------------------
// tks_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/tks_front.sv @@
// ----------------------------------------------------------------------------
// tks_front: input side of the record sorter
// Holds the mode register, masks the name and builds its compare key.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_front #(
  parameter int NAME_BYTES = tks_pkg::DEF_NAME_BYTES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire logic [tks_pkg::ID_W-1:0]   record_id,
  input  wire logic [tks_pkg::NAME_W-1:0] name_chars,
  input  wire logic [tks_pkg::AGE_W-1:0]  age_value,
  input  wire logic                      last_record,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic                      cfg_data,
  input  wire logic                      q_full,
  output      logic                      q_push,
  output      tks_pkg::entry_t           q_entry
);
  import tks_pkg::*;

  localparam logic [NAME_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? '1 :
      ((NAME_W'(1) << (8 * NAME_BYTES)) - NAME_W'(1));
  localparam int ALIGN_SH = NAME_W - 8 * NAME_BYTES;

  logic              sort_mode;
  logic [NAME_W-1:0] name_m;
  logic [NAME_W-1:0] name_left;
  logic [NAME_W-1:0] key;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      sort_mode <= cfg_data;
    end
  end

  assign name_m    = name_chars & NAME_MASK;
  assign name_left = name_m << ALIGN_SH;

  // keep bytes up to the first zero, as a C string compare would
  always_comb begin
    logic alive;
    logic [7:0] b;
    alive = 1'b1;
    key   = '0;
    for (int i = 0; i < 8; i++) begin
      b = name_left[NAME_W-1-8*i -: 8];
      if (b == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key[NAME_W-1-8*i -: 8] = b;
      end
    end
  end

  assign q_push        = push && !q_full;
  assign q_entry.rec.id   = record_id;
  assign q_entry.rec.name = name_m;
  assign q_entry.rec.age  = age_value;
  assign q_entry.key   = key;
  assign q_entry.last  = last_record;
  assign q_entry.mode  = sort_mode;

endmodule

`default_nettype wire

@@ rtl/tks_queue.sv @@
// ----------------------------------------------------------------------------
// tks_queue: short entry queue between front and back
// Lets the front keep taking records while the back sorts or emits.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tks_pkg::entry_t din,
  output      logic            full,
  input  wire logic            pop,
  output      logic            valid,
  output      tks_pkg::entry_t dout
);
  import tks_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign dout    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tks_back.sv @@
// ----------------------------------------------------------------------------
// tks_back: collect, rank and emit stage of the record sorter
// Stores a set, ranks each record by a scan over the set, places it in
// a second RAM at its rank and reads that RAM out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_back #(
  parameter int MAX_RECORDS = tks_pkg::DEF_MAX_RECORDS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire tks_pkg::entry_t q_entry,
  output      logic            q_pop,
  input  wire logic            pop,
  output      logic            out_valid,
  output      tks_pkg::res_t   res
);
  import tks_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int SW = AGE_W + NAME_W;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_FETCH   = 3'd1;
  localparam logic [2:0] S_HOLD    = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          dropped;
  logic          set_mode;
  logic          set_ovf;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] i_idx;
  logic [AW-1:0] cmp_idx;
  logic [AW-1:0] rank;
  logic [AW-1:0] e_idx;
  keyed_t        cur;
  logic          rd_pend;
  logic          rd_last;

  logic          stored;
  logic          a_we;
  logic [AW-1:0] a_raddr;
  keyed_t        a_wdata;
  keyed_t        a_rdata;
  logic          b_we;
  rec_t          b_rdata;
  logic [SW-1:0] cur_sv;
  logic [SW-1:0] j_sv;
  logic          precedes;
  logic [AW-1:0] rank_next;
  logic          scan_done;
  logic          emit_go;

  assign q_pop   = (state == S_COLLECT) && q_valid;
  assign stored  = (count < CW'(MAX_RECORDS));
  assign a_we    = q_pop && stored;
  assign a_wdata = '{rec: q_entry.rec, key: q_entry.key};

  assign cur_sv = set_mode ? {cur.rec.age, cur.key} : {AGE_W'(0), cur.key};
  assign j_sv   = set_mode ? {a_rdata.rec.age, a_rdata.key}
                           : {AGE_W'(0), a_rdata.key};
  // equal keys: the earlier arrival ranks first
  assign precedes  = (j_sv < cur_sv) || ((j_sv == cur_sv) && (cmp_idx < i_idx));
  assign rank_next = rank + AW'(precedes);
  assign scan_done = (state == S_SCAN) && (cmp_idx == last_idx);
  assign b_we      = scan_done;
  assign emit_go   = (state == S_EMIT) && !rd_pend && (!out_valid || pop);

  always_comb begin
    case (state)
      S_FETCH: a_raddr = i_idx;
      S_SCAN:  a_raddr = cmp_idx + AW'(1);
      default: a_raddr = '0;
    endcase
  end

  tks_ram #(
    .WIDTH ($bits(keyed_t)),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (count[AW-1:0]),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  tks_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_RECORDS)
  ) u_sorted (
    .clk   (clk),
    .we    (b_we),
    .waddr (rank_next),
    .wdata (cur.rec),
    .raddr (e_idx),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      count     <= '0;
      dropped   <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (q_pop) begin
            if (q_entry.last) begin
              set_mode <= q_entry.mode;
              set_ovf  <= dropped || !stored;
              last_idx <= stored ? count[AW-1:0] : AW'(MAX_RECORDS - 1);
              i_idx    <= '0;
              count    <= '0;
              dropped  <= 1'b0;
              state    <= S_FETCH;
            end else if (stored) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_FETCH: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          cur     <= a_rdata;
          cmp_idx <= '0;
          rank    <= '0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_done) begin
            if (i_idx == last_idx) begin
              e_idx <= '0;
              state <= S_EMIT;
            end else begin
              i_idx <= i_idx + AW'(1);
              state <= S_FETCH;
            end
          end else begin
            cmp_idx <= cmp_idx + AW'(1);
            rank    <= rank_next;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (e_idx == last_idx) begin
              state <= S_COLLECT;
            end else begin
              e_idx <= e_idx + AW'(1);
            end
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase

      if (emit_go) begin
        rd_pend <= 1'b1;
        rd_last <= (e_idx == last_idx);
      end else if (rd_pend) begin
        rd_pend <= 1'b0;
      end

      // load the read result into the output slot, or drop a taken one
      if (rd_pend) begin
        out_valid <= 1'b1;
        res.rec   <= b_rdata;
        res.last  <= rd_last;
        res.ovf   <= set_ovf;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tks_checker.sv @@
// ----------------------------------------------------------------------------
// tks_checker: port-level checks of the record sorter
// Watches the queue-style handshakes at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] out_id,
  input wire logic [63:0] out_name
);

  // reset leaves no result shown and room for input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("result shown or queue full after reset");

  // hold a waiting result until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_id) && $stable(out_name)))
    else $error("waiting result changed or vanished");

  // full never rises without an accepted transaction
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("full rose without an input transaction");

  // the output slot refills through a RAM read, so it is empty after a pop
  a_slot_refill: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("result shown in the cycle after a pop");

endmodule

bind two_key_record_sorter tks_checker u_tks_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_id   (out_id),
  .out_name (out_name)
);

`default_nettype wire

@@ tb/tks_sort_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tks_sort_checker: scoreboard for the two-key record sorter
// Watches the record, result and mode channels, keeps its own copy of the
// record set, ranks it when the last record arrives and compares every
// popped result with the oldest ranked record still owed.
// ----------------------------------------------------------------------------
module tks_sort_checker #(
  parameter int MAX_RECORDS = tks_pkg::DEF_MAX_RECORDS,
  parameter int NAME_BYTES  = tks_pkg::DEF_NAME_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic [tks_pkg::ID_W-1:0]    record_id,
  input  logic [tks_pkg::NAME_W-1:0]  name_chars,
  input  logic [tks_pkg::AGE_W-1:0]   age_value,
  input  logic                        last_record,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [tks_pkg::ID_W-1:0]    out_id,
  input  logic [tks_pkg::NAME_W-1:0]  out_name,
  input  logic [tks_pkg::AGE_W-1:0]   out_age,
  input  logic                        out_last,
  input  logic                        overflow_flag,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_data,
  output int                          sort_failures,
  output int                          sorted_pending,
  output int                          results_checked
);
  import tks_pkg::*;

  localparam logic [NAME_W-1:0] NAME_MASK =
    (NAME_BYTES >= 8) ? {NAME_W{1'b1}} : ((NAME_W'(1) << (8 * NAME_BYTES)) - 1);

  rec_t held_records [MAX_RECORDS];
  int   held_count;
  logic set_dropped;
  logic order_by_age;
  res_t sorted_records [$];
  res_t owed;
  rec_t incoming;

  initial begin
    sort_failures   = 0;
    sorted_pending  = 0;
    results_checked = 0;
    held_count      = 0;
    set_dropped     = 1'b0;
    order_by_age    = 1'b0;
  end

  // string view of the name: left-aligned, cut at the first zero byte
  function automatic logic [NAME_W-1:0] name_key_of(input logic [NAME_W-1:0] name);
    logic [NAME_W-1:0] key;
    logic [7:0]        ch;
    logic              ended;
    key   = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      ch = name[8 * (NAME_BYTES - 1 - i) +: 8];
      if (ch == 8'h00) ended = 1'b1;
      if (!ended) key[NAME_W - 8 - 8 * i +: 8] = ch;
    end
    return key;
  endfunction

  function automatic logic ranks_ahead(input rec_t a, input rec_t b);
    if (order_by_age && a.age != b.age) return a.age < b.age;
    return name_key_of(a.name) < name_key_of(b.name);
  endfunction

  // stable insertion ranking of the held set, then owe one result per record
  function automatic void rank_held_set();
    int   order [MAX_RECORDS];
    int   j;
    res_t r;
    for (int i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0 && ranks_ahead(held_records[i], held_records[order[j-1]])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < held_count; i++) begin
      r.rec  = held_records[order[i]];
      r.last = (i == held_count - 1);
      r.ovf  = set_dropped;
      sorted_records.push_back(r);
    end
    held_count  = 0;
    set_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_count   = 0;
      set_dropped  = 1'b0;
      order_by_age = 1'b0;
      sorted_records.delete();
    end else begin
      if (cfg_valid && cfg_ready) order_by_age = cfg_data;

      if (pop && !empty) begin
        results_checked++;
        if (sorted_records.size() == 0) begin
          $error("result with nothing owed: out_id %h out_name %h", out_id, out_name);
          sort_failures++;
        end else begin
          owed = sorted_records.pop_front();
          if (out_id !== owed.rec.id) begin
            $error("out_id: expected %h, actual %h", owed.rec.id, out_id);
            sort_failures++;
          end
          if (out_name !== owed.rec.name) begin
            $error("out_name: expected %h, actual %h", owed.rec.name, out_name);
            sort_failures++;
          end
          if (out_age !== owed.rec.age) begin
            $error("out_age: expected %h, actual %h", owed.rec.age, out_age);
            sort_failures++;
          end
          if (out_last !== owed.last) begin
            $error("out_last: expected %b, actual %b", owed.last, out_last);
            sort_failures++;
          end
          if (overflow_flag !== owed.ovf) begin
            $error("overflow_flag: expected %b, actual %b", owed.ovf, overflow_flag);
            sort_failures++;
          end
        end
      end

      if (push && !full) begin
        // drop the record when the set already fills the store
        if (held_count < MAX_RECORDS) begin
          incoming.id  = record_id;
          incoming.name = name_chars & NAME_MASK;
          incoming.age = age_value;
          held_records[held_count] = incoming;
          held_count++;
        end else begin
          set_dropped = 1'b1;
        end
        if (last_record) rank_held_set();
      end
    end
    sorted_pending = sorted_records.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression for the two-key record sorter
// Sends directed and random record sets in both sort orders, with random
// gaps on the record and result queues, including a full set and a set past
// capacity; the checker beside the block ranks each set and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import tks_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 210;
  localparam int SETTLE_CYCLES = 16;
  localparam int CAPACITY      = DEF_MAX_RECORDS;

  // short names, all ending by the fourth byte, so garbage may follow
  localparam logic [NAME_W-1:0] NAME_ANN = 64'h414E_4E00_0000_0000;
  localparam logic [NAME_W-1:0] NAME_BOB = 64'h424F_4200_0000_0000;
  localparam logic [NAME_W-1:0] NAME_AL  = 64'h414C_0000_0000_0000;
  localparam logic [NAME_W-1:0] NAME_ZED = 64'h5A45_4400_0000_0000;

  logic              clk;
  logic              rst;
  logic              push        = 1'b0;
  logic              full;
  logic [ID_W-1:0]   record_id   = '0;
  logic [NAME_W-1:0] name_chars  = '0;
  logic [AGE_W-1:0]  age_value   = '0;
  logic              last_record = 1'b0;
  logic              empty;
  logic              pop         = 1'b0;
  logic [ID_W-1:0]   out_id;
  logic [NAME_W-1:0] out_name;
  logic [AGE_W-1:0]  out_age;
  logic              out_last;
  logic              overflow_flag;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic              cfg_data    = 1'b0;

  int   sort_failures;
  int   sorted_pending;
  int   results_checked;
  int   cycle_count   = 0;
  int   records_sent  = 0;
  int   sets_sent     = 0;
  int   overfull_sets = 0;
  int   mode_writes   = 0;
  logic tx_steady     = 1'b0;
  logic rx_steady     = 1'b0;
  logic rx_took       = 1'b0;
  int   rx_hold       = 0;

  two_key_record_sorter i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .record_id(record_id), .name_chars(name_chars), .age_value(age_value),
    .last_record(last_record),
    .empty(empty), .pop(pop),
    .out_id(out_id), .out_name(out_name), .out_age(out_age),
    .out_last(out_last), .overflow_flag(overflow_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  tks_sort_checker i_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .record_id(record_id), .name_chars(name_chars), .age_value(age_value),
    .last_record(last_record),
    .empty(empty), .pop(pop),
    .out_id(out_id), .out_name(out_name), .out_age(out_age),
    .out_last(out_last), .overflow_flag(overflow_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .sort_failures(sort_failures), .sorted_pending(sorted_pending),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               sorted_pending);
      $display("two_key_record_sorter regression: fail");
      $finish;
    end
  end

  // result side: hold pop low for a random stretch after each transaction
  always @(posedge clk) rx_took = pop && !empty;

  always @(negedge clk) begin
    if (rx_took) rx_hold = rx_steady ? 0 : $urandom_range(0, 3);
    if (rx_hold != 0) begin
      pop <= 1'b0;
      rx_hold--;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_record(input logic [ID_W-1:0] id, input logic [NAME_W-1:0] name,
                             input logic [AGE_W-1:0] age, input logic is_last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    record_id   <= id;
    name_chars  <= name;
    age_value   <= age;
    last_record <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    records_sent++;
    if (is_last) sets_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (sorted_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sort_mode(input logic by_age);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= by_age;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] name;
    logic [NAME_W-1:0] pool [4];
    int                kept;
    pool[0] = NAME_ANN;
    pool[1] = NAME_BOB;
    pool[2] = NAME_AL;
    pool[3] = NAME_ZED;
    name = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: name = pool[$urandom_range(0, 3)];
      // pool name with junk after its terminator: same key, different bytes
      2: name = pool[$urandom_range(0, 3)] | {32'h0, name[31:0]};
      3: begin
        kept = $urandom_range(1, 7);
        name = name & ({NAME_W{1'b1}} << (8 * (8 - kept)));
      end
      4: name[8 * $urandom_range(0, 7) +: 8] = 8'h00;
      default: ;
    endcase
    return name;
  endfunction

  function automatic logic [AGE_W-1:0] random_age();
    if ($urandom_range(0, 2) == 0) return AGE_W'($urandom_range(0, 255));
    return AGE_W'($urandom_range(30, 33));
  endfunction

  task automatic send_random_set(input int count);
    for (int i = 0; i < count; i++)
      send_record(ID_W'($urandom), random_name(), random_age(), i == count - 1);
    if (count > CAPACITY) overfull_sets++;
  endtask

  initial begin
    int set_no;
    int set_size;
    int random_sent;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // name order straight out of reset: extremes, empty names, junk after zero
    send_record(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b0);
    send_record(16'hFFFF, 64'h0000_0000_0000_0000, 8'd0,   1'b0);
    send_record(16'h0001, 64'h4142_00A5_5AFF_0102, 8'd10,  1'b0);
    send_record(16'h0002, 64'h4142_0000_0000_0000, 8'd200, 1'b0);
    send_record(16'h0003, 64'h4142_4300_0000_0000, 8'd10,  1'b0);
    send_record(16'h0004, 64'h0011_2233_4455_6677, 8'd128, 1'b0);
    send_record(16'h0005, 64'h8000_0000_0000_0001, 8'd127, 1'b0);
    send_record(16'h0006, 64'h7FFF_FFFF_FFFF_FFFF, 8'd1,   1'b1);
    // one-record set
    send_record(16'h1234, NAME_ZED, 8'd77, 1'b1);

    // age order, name breaking ties, equal keys staying in arrival order
    write_sort_mode(1'b1);
    send_record(16'h0100, NAME_ANN, 8'd255, 1'b0);
    send_record(16'h0101, NAME_ZED, 8'd0,   1'b0);
    send_record(16'h0102, NAME_BOB, 8'd0,   1'b0);
    send_record(16'h0103, NAME_AL,  8'd50,  1'b0);
    send_record(16'h0104, NAME_AL | 64'h0000_0000_DEAD_BEEF, 8'd50, 1'b0);
    send_record(16'h0105, NAME_ANN, 8'd50,  1'b0);
    send_record(16'h0106, NAME_BOB, 8'd0,   1'b0);
    send_record(16'h0107, 64'h0,    8'd255, 1'b1);

    write_sort_mode(1'b0);
    set_no      = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_sort_mode(1'($urandom_range(0, 1)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (set_no == 2) set_size = CAPACITY;
      else if (set_no == 5) set_size = CAPACITY + 1;
      else if ($urandom_range(0, 5) == 0) set_size = $urandom_range(9, 20);
      else set_size = $urandom_range(1, 8);
      send_random_set(set_size);
      random_sent += set_size;
      set_no++;
    end

    drain_results();
    $display("sent %0d records in %0d sets, %0d of them past capacity, %0d mode writes",
             records_sent, sets_sent, overfull_sets, mode_writes);
    $display("checked %0d sorted results, %0d mismatches", results_checked, sort_failures);
    if (sort_failures == 0) begin
      $display("two_key_record_sorter regression: pass");
    end else begin
      $display("two_key_record_sorter regression: fail");
    end
    $finish;
  end

endmodule
